### src/bimt_pkg.sv
`timescale 1ns / 1ps
// shared constants and the link type for the bidirectional id map table
// no dependencies

package bimt_pkg;

    localparam int TABLE_DEPTH_DEF  = 64;
    localparam int GLOBAL_WIDTH_DEF = 64;

    localparam int KEY_W    = 64;
    localparam int GVAL_W   = 64;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 7;
    localparam int TDATA_W  = 136;

    localparam logic [ENTRY_W-1:0] ENTRIES_RESET = 7'd64;

    localparam logic [MODE_W-1:0] MODE_INSERT       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP_LOCAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP_GLOB  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // token and completion flag handed from one cell to the next
    typedef struct packed {
        logic tok;
        logic done;
    } link_t;

endpackage

### src/bimt_cell.sv
`timescale 1ns / 1ps
// one table slot of the map chain: holds a local/global pair and serves the passing request
// depends on bimt_pkg

module bimt_cell #(
    parameter int TABLE_DEPTH  = bimt_pkg::TABLE_DEPTH_DEF,
    parameter int GLOBAL_WIDTH = bimt_pkg::GLOBAL_WIDTH_DEF,
    parameter int CELL_INDEX   = 0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [bimt_pkg::ENTRY_W-1:0]   entries,
    input  logic [bimt_pkg::MODE_W-1:0]    mode,
    input  logic [bimt_pkg::KEY_W-1:0]     key,
    input  logic [GLOBAL_WIDTH-1:0]        gval,
    input  bimt_pkg::link_t                link_in,
    input  logic [bimt_pkg::KEY_W-1:0]     res_in,
    output bimt_pkg::link_t                link_out,
    output logic [bimt_pkg::KEY_W-1:0]     res_out
);

    localparam int RES_W   = bimt_pkg::KEY_W;
    localparam int DEPTH_W = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W   = (DEPTH_W > bimt_pkg::ENTRY_W) ? DEPTH_W : bimt_pkg::ENTRY_W;
    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(CELL_INDEX);

    logic [RES_W-1:0]        local_reg;
    logic [GLOBAL_WIDTH-1:0] global_reg;
    bimt_pkg::link_t         link_reg;
    logic [RES_W-1:0]        res_reg;

    logic             active;
    logic             match;
    logic             hit;
    logic [RES_W-1:0] hit_value;

    assign active = IDX_C < CNT_W'(entries);

    always_comb
    begin
        match     = 1'b0;
        hit_value = '0;
        case (mode)
            bimt_pkg::MODE_INSERT:
            begin
                match = (local_reg == '0);
            end
            bimt_pkg::MODE_LOOKUP_LOCAL:
            begin
                match     = (local_reg != '0) && (local_reg == key);
                hit_value = RES_W'(global_reg);
            end
            bimt_pkg::MODE_LOOKUP_GLOB:
            begin
                match     = (local_reg != '0) && (global_reg == gval);
                hit_value = local_reg;
            end
            default:
            begin
                match = 1'b0;
            end
        endcase
    end

    assign hit = link_in.tok && !link_in.done && active && match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_reg  <= '0;
            global_reg <= '0;
            link_reg   <= '0;
        end
        else
        begin
            if (hit && (mode == bimt_pkg::MODE_INSERT))
            begin
                local_reg  <= key;
                global_reg <= gval;
            end
            link_reg.tok  <= link_in.tok;
            link_reg.done <= link_in.done || hit;
        end
    end

    // result word follows the token, so it needs no reset
    always_ff @(posedge clk)
    begin
        res_reg <= hit ? hit_value : res_in;
    end

    assign link_out = link_reg;
    assign res_out  = res_reg;

endmodule

### src/bidirectional_id_map_table_top.sv
`timescale 1ns / 1ps
// path: start register, the cell registers of the chain, the holding stage, then the output register
// one request at a time; the request token walks the cell chain
//   one slot per cycle, and a new request is taken once the previous result reaches the output
// reset: every slot cleared (all free), entries_in_use back to 64, both sides idle
// depends on bimt_pkg and bimt_cell

module bidirectional_id_map_table_top #(
    parameter int TABLE_DEPTH  = bimt_pkg::TABLE_DEPTH_DEF,
    parameter int GLOBAL_WIDTH = bimt_pkg::GLOBAL_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration: entries_in_use
    input  logic                             cfg_we,
    input  logic [bimt_pkg::ENTRY_W-1:0]     cfg_wdata,
    // request side
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bimt_pkg::TDATA_W-1:0]     s_tdata,   // mode[1:0], local_key[65:2], global_value[129:66]
    // result side
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bimt_pkg::TDATA_W-1:0]     m_tdata    // status[1:0], local_out[65:2], global_out[129:66]
);

    localparam int KW = bimt_pkg::KEY_W;
    localparam int MW = bimt_pkg::MODE_W;
    localparam int SW = bimt_pkg::STATUS_W;

    // field positions inside tdata
    localparam int MODE_LO = 0;
    localparam int KEY_LO  = MODE_LO + MW;
    localparam int GVAL_LO = KEY_LO + KW;
    localparam int PAD_LO  = GVAL_LO + bimt_pkg::GVAL_W;

    // configuration register
    logic [bimt_pkg::ENTRY_W-1:0] entries_reg;

    // request held for the whole walk down the chain
    logic [MW-1:0]            mode_reg;
    logic [KW-1:0]            key_reg;
    logic [GLOBAL_WIDTH-1:0]  gval_reg;
    logic                     start_reg;
    logic                     busy_reg;

    // end-of-chain holding stage and output register
    logic                     pend_valid_reg;
    logic                     pend_done_reg;
    logic [KW-1:0]            pend_res_reg;
    logic                     out_valid_reg;
    logic [SW-1:0]            out_status_reg;
    logic [KW-1:0]            out_local_reg;
    logic [KW-1:0]            out_global_reg;

    logic [SW-1:0]            status_next;
    logic [KW-1:0]            local_next;
    logic [KW-1:0]            global_next;

    logic                     in_xfer;
    logic                     pend_move;

    bimt_pkg::link_t          link [TABLE_DEPTH+1];
    logic [KW-1:0]            res  [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0]   tok_vec;

    assign s_tready  = !busy_reg;
    assign in_xfer   = s_tvalid && s_tready;
    // the pending result moves out when the output register is empty or being drained
    assign pend_move = pend_valid_reg && (!out_valid_reg || m_tready);

    // chain head: token enters with nothing found yet (tok, done)
    assign link[0] = {start_reg, 1'b0};
    assign res[0]  = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        bimt_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .GLOBAL_WIDTH(GLOBAL_WIDTH),
            .CELL_INDEX  (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .entries (entries_reg),
            .mode    (mode_reg),
            .key     (key_reg),
            .gval    (gval_reg),
            .link_in (link[i]),
            .res_in  (res[i]),
            .link_out(link[i+1]),
            .res_out (res[i+1])
        );
        assign tok_vec[i] = link[i+1].tok;
    end

    // final answer from the completion flag and the request kind
    always_comb
    begin
        local_next  = '0;
        global_next = '0;
        if (pend_done_reg)
        begin
            status_next = bimt_pkg::ST_OK;
        end
        else if (mode_reg == bimt_pkg::MODE_INSERT)
        begin
            status_next = bimt_pkg::ST_NO_SPACE;
        end
        else
        begin
            status_next = bimt_pkg::ST_NOT_FOUND;
        end
        if (pend_done_reg && (mode_reg == bimt_pkg::MODE_LOOKUP_GLOB))
        begin
            local_next = pend_res_reg;
        end
        if (pend_done_reg && (mode_reg == bimt_pkg::MODE_LOOKUP_LOCAL))
        begin
            global_next = pend_res_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg    <= bimt_pkg::ENTRIES_RESET;
            start_reg      <= 1'b0;
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                entries_reg <= cfg_wdata;
            end
            start_reg <= in_xfer;
            if (in_xfer)
            begin
                busy_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                busy_reg <= 1'b0;
            end
            // token leaving the last cell lands in the holding stage
            if (link[TABLE_DEPTH].tok)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg <= s_tdata[MODE_LO +: MW];
            key_reg  <= s_tdata[KEY_LO +: KW];
            gval_reg <= s_tdata[GVAL_LO +: GLOBAL_WIDTH];
        end
        if (link[TABLE_DEPTH].tok)
        begin
            pend_done_reg <= link[TABLE_DEPTH].done;
            pend_res_reg  <= res[TABLE_DEPTH];
        end
        if (pend_move)
        begin
            out_status_reg <= status_next;
            out_local_reg  <= local_next;
            out_global_reg <= global_next;
        end
    end

    assign m_tvalid                            = out_valid_reg;
    assign m_tdata[MODE_LO +: SW]              = out_status_reg;
    assign m_tdata[KEY_LO +: KW]               = out_local_reg;
    assign m_tdata[GVAL_LO +: KW]              = out_global_reg;
    assign m_tdata[bimt_pkg::TDATA_W-1:PAD_LO] = '0;

    // at most one request token in the chain at any time
    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one token in the cell chain");

    // a token in the chain or a held result means the block is busy
    a_busy_cover: assert property (@(posedge clk) disable iff (!rst_n)
        ((|tok_vec) || start_reg || pend_valid_reg) |-> busy_reg)
        else $error("request in flight while input side is ready");

    // an accepted request always launches a token on the next cycle
    a_launch: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (start_reg && busy_reg))
        else $error("accepted request did not enter the chain");

endmodule

### verif/bidirectional_id_map_table_top_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the bidirectional id map table
// depends on bimt_pkg and bidirectional_id_map_table_top

module bidirectional_id_map_table_top_test;

    // mode three has no name in the package, the block must answer not found
    localparam logic [bimt_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int TABLE_DEPTH = bimt_pkg::TABLE_DEPTH_DEF;
    localparam int POOL_SIZE   = 16;
    localparam int PHASE_ITEMS = 200;
    localparam int NUM_PHASES  = 8;
    // slowest run: ~1650 transfers, each a full scan of the chain plus a random send gap and ready stall
    localparam int CYCLE_LIMIT = 1_000_000;

    localparam logic [bimt_pkg::KEY_W-1:0] ALL_ONES = {bimt_pkg::KEY_W{1'b1}};

    // one result transfer, split into its fields
    typedef struct packed {
        logic [bimt_pkg::STATUS_W-1:0] status;
        logic [bimt_pkg::KEY_W-1:0]    local_out;
        logic [bimt_pkg::GVAL_W-1:0]   global_out;
    } map_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [bimt_pkg::ENTRY_W-1:0]   cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [bimt_pkg::TDATA_W-1:0]   s_tdata;   // mode[1:0], local_key[65:2], global_value[129:66]
    logic                           m_tvalid;
    logic                           m_tready;
    logic [bimt_pkg::TDATA_W-1:0]   m_tdata;   // status[1:0], local_out[65:2], global_out[129:66]

    // shadow copy of the table and of the slot count register
    logic [bimt_pkg::KEY_W-1:0]     shadow_local [TABLE_DEPTH];
    logic [bimt_pkg::GVAL_W-1:0]    shadow_global[TABLE_DEPTH];
    logic [bimt_pkg::ENTRY_W-1:0]   shadow_slot_count = bimt_pkg::ENTRIES_RESET;

    // results predicted at request acceptance, oldest first
    map_result_t                    pending_results[$];

    // identifiers reused across random requests so that lookups hit
    logic [bimt_pkg::KEY_W-1:0]     known_locals [POOL_SIZE];
    logic [bimt_pkg::GVAL_W-1:0]    known_globals[POOL_SIZE];

    int unsigned          send_gap_max    = 14;
    int unsigned          ready_stall_max = 14;
    int                   err_cnt         = 0;
    int                   cycle_count     = 0;

    bidirectional_id_map_table_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    // watchdog against a hung handshake
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bidirectional_id_map_table_top_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            shadow_local[i]  = '0;
            shadow_global[i] = '0;
        end
    end

    // predicted effect of one request on the shadow table, and its answer
    function automatic map_result_t compute_map_result(
        input logic [bimt_pkg::MODE_W-1:0] mode,
        input logic [bimt_pkg::KEY_W-1:0]  key,
        input logic [bimt_pkg::GVAL_W-1:0] gval);
        map_result_t res;
        int          active;
        res.status     = bimt_pkg::ST_NOT_FOUND;
        res.local_out  = '0;
        res.global_out = '0;
        // counts above the table size clamp to the table size
        active = (int'(shadow_slot_count) > TABLE_DEPTH) ? TABLE_DEPTH
                                                         : int'(shadow_slot_count);
        case (mode)
            bimt_pkg::MODE_INSERT:
            begin
                // lowest free slot wins, no duplicate check; a zero local leaves it free
                res.status = bimt_pkg::ST_NO_SPACE;
                for (int i = 0; i < active; i++)
                begin
                    if (shadow_local[i] == '0)
                    begin
                        shadow_local[i]  = key;
                        shadow_global[i] = gval;
                        res.status       = bimt_pkg::ST_OK;
                        break;
                    end
                end
            end
            bimt_pkg::MODE_LOOKUP_LOCAL:
            begin
                for (int i = 0; i < active; i++)
                begin
                    if (shadow_local[i] != '0 && shadow_local[i] == key)
                    begin
                        res.global_out = shadow_global[i];
                        res.status     = bimt_pkg::ST_OK;
                        break;
                    end
                end
            end
            bimt_pkg::MODE_LOOKUP_GLOB:
            begin
                for (int i = 0; i < active; i++)
                begin
                    if (shadow_local[i] != '0 && shadow_global[i] == gval)
                    begin
                        res.local_out = shadow_local[i];
                        res.status    = bimt_pkg::ST_OK;
                        break;
                    end
                end
            end
            default:
            begin
                // unused mode: no state change, not found with zero identifiers
            end
        endcase
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // one request transfer; s_tvalid stays high so back-to-back items need no drop
    task automatic send_map_request(input logic [bimt_pkg::MODE_W-1:0] mode,
                                    input logic [bimt_pkg::KEY_W-1:0]  key,
                                    input logic [bimt_pkg::GVAL_W-1:0] gval);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(bimt_pkg::TDATA_W - bimt_pkg::MODE_W - bimt_pkg::KEY_W
                       - bimt_pkg::GVAL_W){1'b0}}, gval, key, mode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(compute_map_result(mode, key, gval));
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // slot count register is only written with the table idle
    task automatic write_slot_count(input logic [bimt_pkg::ENTRY_W-1:0] value);
        wait_for_idle();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we            <= 1'b0;
        shadow_slot_count  = value;
    endtask

    // result side: random stalls on m_tready, field-by-field compare per transfer
    initial
    begin : result_checker
        int unsigned stall;
        map_result_t exp_res;
        map_result_t got_res;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        stall = $urandom_range(0, ready_stall_max);
        forever
        begin
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            got_res.status     = m_tdata[1:0];
            got_res.local_out  = m_tdata[65:2];
            got_res.global_out = m_tdata[129:66];
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no request outstanding: status %0d", got_res.status);
                err_cnt++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (got_res.status !== exp_res.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_res.status, got_res.status);
                    err_cnt++;
                end
                if (got_res.local_out !== exp_res.local_out)
                begin
                    $error("local_out mismatch: expected %h, actual %h",
                           exp_res.local_out, got_res.local_out);
                    err_cnt++;
                end
                if (got_res.global_out !== exp_res.global_out)
                begin
                    $error("global_out mismatch: expected %h, actual %h",
                           exp_res.global_out, got_res.global_out);
                    err_cnt++;
                end
            end
            stall = $urandom_range(0, ready_stall_max);
        end
    end

    // cleared table: every slot free, so nothing can be found
    task automatic test_empty_table();
        send_map_request(bimt_pkg::MODE_LOOKUP_LOCAL, '0, '0);
        send_map_request(bimt_pkg::MODE_LOOKUP_GLOB, '0, '0);
        send_map_request(bimt_pkg::MODE_LOOKUP_GLOB, ALL_ONES, ALL_ONES);
        send_map_request(MODE_UNUSED, ALL_ONES, ALL_ONES);
    endtask

    // inserts at the field extremes, duplicates, zero local, hits and misses
    task automatic test_insert_and_lookup();
        send_map_request(bimt_pkg::MODE_INSERT, ALL_ONES, ALL_ONES);
        send_map_request(bimt_pkg::MODE_INSERT, 64'd1, '0);
        // zero local fills the free slot's global but leaves it free
        send_map_request(bimt_pkg::MODE_INSERT, '0, 64'h5555_5555_5555_5555);
        send_map_request(bimt_pkg::MODE_LOOKUP_GLOB, '0, 64'h5555_5555_5555_5555);
        // duplicate local lands in the same still-free slot
        send_map_request(bimt_pkg::MODE_INSERT, ALL_ONES, 64'h1234_5678_9abc_def0);
        send_map_request(bimt_pkg::MODE_LOOKUP_LOCAL, ALL_ONES, '0);
        send_map_request(bimt_pkg::MODE_LOOKUP_GLOB, '0, 64'h1234_5678_9abc_def0);
        send_map_request(bimt_pkg::MODE_LOOKUP_GLOB, ALL_ONES, '0);
        // key zero never matches, free slots included
        send_map_request(bimt_pkg::MODE_LOOKUP_LOCAL, '0, ALL_ONES);
        send_map_request(bimt_pkg::MODE_LOOKUP_LOCAL, 64'd2, '0);
        send_map_request(MODE_UNUSED, '0, '0);
    endtask

    // zero, single and oversized slot counts against the three occupied slots
    task automatic test_slot_count_limits();
        write_slot_count(7'd0);
        send_map_request(bimt_pkg::MODE_INSERT, 64'hdead_beef, 64'hfeed);
        send_map_request(bimt_pkg::MODE_LOOKUP_LOCAL, ALL_ONES, '0);
        send_map_request(bimt_pkg::MODE_LOOKUP_GLOB, '0, ALL_ONES);
        write_slot_count(7'd1);
        send_map_request(bimt_pkg::MODE_LOOKUP_GLOB, '0, '0);
        send_map_request(bimt_pkg::MODE_INSERT, 64'h77, 64'h88);
        write_slot_count(7'd127);
        send_map_request(bimt_pkg::MODE_LOOKUP_GLOB, '0, '0);
        send_map_request(bimt_pkg::MODE_INSERT, 64'h99, ALL_ONES);
    endtask

    function automatic logic [bimt_pkg::KEY_W-1:0] pick_local();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return known_locals[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 80)
            return '0;
        return rand64();
    endfunction

    function automatic logic [bimt_pkg::GVAL_W-1:0] pick_global();
        if ($urandom_range(0, 99) < 75)
            return known_globals[$urandom_range(0, POOL_SIZE - 1)];
        return rand64();
    endfunction

    // lookup-heavy mix; inserts kept rare so the table fills across the run
    task automatic send_random_request();
        int unsigned                   pick;
        logic [bimt_pkg::MODE_W-1:0]   mode;
        logic [bimt_pkg::KEY_W-1:0]    key;
        logic [bimt_pkg::GVAL_W-1:0]   gval;
        pick = $urandom_range(0, 99);
        key  = pick_local();
        gval = pick_global();
        if (pick < 7)
        begin
            mode = bimt_pkg::MODE_INSERT;
            if ($urandom_range(0, 9) == 0)
                key = '0;
        end
        else if (pick < 50)
            mode = bimt_pkg::MODE_LOOKUP_LOCAL;
        else if (pick < 93)
            mode = bimt_pkg::MODE_LOOKUP_GLOB;
        else
            mode = MODE_UNUSED;
        send_map_request(mode, key, gval);
    endtask

    // phases with differing slot counts and idle patterns
    task automatic test_random_traffic();
        logic [bimt_pkg::ENTRY_W-1:0] phase_counts[NUM_PHASES];
        phase_counts = '{7'd8, 7'd64, 7'd0, 7'd127, 7'd1, 7'd40, 7'd65, 7'd64};
        phase_counts[6] = 7'($urandom_range(0, 127));
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            known_locals[i]  = rand64();
            known_globals[i] = rand64();
            if (known_locals[i] == '0)
                known_locals[i] = 64'd1;
        end
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_slot_count(phase_counts[p]);
            // phase 2 runs with no idling on either side, phase 5 with a ready sink only
            send_gap_max    = (p == 2) ? 0 : 14;
            ready_stall_max = (p == 2 || p == 5) ? 0 : 14;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_request();
        end
        send_gap_max    = 14;
        ready_stall_max = 14;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_insert_and_lookup();
        test_slot_count_limits();
        test_random_traffic();

        // drain, then allow a full scan for any stray result
        wait_for_idle();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("bidirectional_id_map_table_top_test OK");
        else
            $display("bidirectional_id_map_table_top_test NOT OK");
        $finish;
    end

endmodule
